>>> rtl/core/uniform_cubic_bspline_point_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the uniform cubic B-spline point evaluator
// Each macro checks a property on the rising clock edge, outside reset.
// ----------------------------------------------------------------------------
`ifndef UNIFORM_CUBIC_BSPLINE_POINT_ASSERT_SVH
`define UNIFORM_CUBIC_BSPLINE_POINT_ASSERT_SVH

`ifndef SYNTH
`define UCBSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle property violated");
`define UCBSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle property violated");
`else
`define UCBSP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define UCBSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/ucbsp_pkg.sv
// ----------------------------------------------------------------------------
// ucbsp_pkg
// Shared constants and types of the uniform cubic B-spline point evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ucbsp_pkg;

    localparam int MAX_KNOTS = 64;
    localparam int IDX_W     = 6;
    localparam int COUNT_W   = 7;
    localparam int COORD_W   = 32;
    localparam int MU_W      = 17;
    localparam int NUM_TERMS = 4;
    localparam int TERM_W    = 2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic [IDX_W-1:0]          knot_index;
        logic signed [COORD_W-1:0] knot_x;
        logic signed [COORD_W-1:0] knot_y;
        logic signed [COORD_W-1:0] knot_z;
        logic [MU_W-1:0]           mu;
    } req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } result_t;

    typedef struct packed {
        logic              load_we;
        logic              eval_start;
        logic              sq_en;
        logic              cube_en;
        logic              num_en;
        logic              div_en;
        logic              rd_en;
        logic [TERM_W-1:0] rd_term;
        logic              acc_clr;
    } dp_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/uniform_cubic_bspline_point.sv
// ----------------------------------------------------------------------------
// uniform_cubic_bspline_point
// Evaluates a uniform cubic B-spline curve over stored 3-D knots.
//
//   Channel   Ports                        Transfer
//   request   start, busy, req             start high while busy low
//   result    done, result                 done high for one cycle
//   config    cfg_wen, cfg_wdata           cfg_wen high, no wait
//
// A load transaction gives no result.
// An evaluate transaction raises done after weight computation in the SQ, CUBE,
// NUM and DIV states, followed by the MAC state, in which one shared
// multiply-accumulate takes the four knot terms through its memory read,
// multiply and add stages. A new transaction is accepted in the done cycle,
// but not while an evaluation is busy. The receiver cannot stall results.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "uniform_cubic_bspline_point_assert.svh"

module uniform_cubic_bspline_point (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire ucbsp_pkg::req_t               req,
    output logic                               done,
    output ucbsp_pkg::result_t                 result,
    input  wire logic                          cfg_wen,
    input  wire logic [ucbsp_pkg::COUNT_W-1:0] cfg_wdata
);

    ucbsp_pkg::dp_cmd_t cmd;

    ucbsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd)
    );

    ucbsp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    `UCBSP_ASSERT_NEXT(a_eval_sets_busy, clk, rst_n, start && !busy && (req.req_type == ucbsp_pkg::REQ_EVAL), busy)
    `UCBSP_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `UCBSP_ASSERT_IMPL(a_read_while_busy, clk, rst_n, cmd.rd_en, busy)
    `UCBSP_ASSERT_IMPL(a_no_load_write_busy, clk, rst_n, busy, !cmd.load_we && !cmd.eval_start)

endmodule

`default_nettype wire

>>> rtl/core/ucbsp_ctrl.sv
// ----------------------------------------------------------------------------
// ucbsp_ctrl
// Sequencer that steps the datapath through weight computation and the
// multiply-accumulate over the four knot terms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucbsp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               req_type,
    output logic                    busy,
    output logic                    done,
    output ucbsp_pkg::dp_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_CUBE,
        ST_NUM,
        ST_DIV,
        ST_MAC,
        ST_OUT
    } state_t;

    localparam logic [2:0] MAC_LAST = 3'(ucbsp_pkg::NUM_TERMS + 1);

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       done_reg;
    logic       done_next;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE) && (state_reg != ST_OUT);
    assign done   = done_reg;
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE, ST_OUT:
            begin
                if (accept && (req_type == ucbsp_pkg::REQ_EVAL))
                begin
                    state_next = ST_SQ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SQ:   state_next = ST_CUBE;
            ST_CUBE: state_next = ST_NUM;
            ST_NUM:  state_next = ST_DIV;
            ST_DIV:
            begin
                state_next = ST_MAC;
                cnt_next   = '0;
            end
            ST_MAC:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == MAC_LAST)
                begin
                    state_next = ST_OUT;
                    done_next  = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.load_we    = accept && (req_type == ucbsp_pkg::REQ_LOAD);
        cmd.eval_start = accept && (req_type == ucbsp_pkg::REQ_EVAL);
        cmd.sq_en      = (state_reg == ST_SQ);
        cmd.cube_en    = (state_reg == ST_CUBE);
        cmd.num_en     = (state_reg == ST_NUM);
        cmd.div_en     = (state_reg == ST_DIV);
        cmd.acc_clr    = (state_reg == ST_DIV);
        cmd.rd_en      = (state_reg == ST_MAC) && (cnt_reg < 3'(ucbsp_pkg::NUM_TERMS));
        cmd.rd_term    = cnt_reg[ucbsp_pkg::TERM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ucbsp_datapath.sv
// ----------------------------------------------------------------------------
// ucbsp_datapath
// Knot memory, knot count register, basis weight pipeline and the
// three-coordinate multiply-accumulate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucbsp_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ucbsp_pkg::dp_cmd_t                  cmd,
    input  wire ucbsp_pkg::req_t                     req,
    input  wire logic                                cfg_wen,
    input  wire logic [ucbsp_pkg::COUNT_W-1:0]       cfg_wdata,
    output ucbsp_pkg::result_t                       result
);

    localparam int T_W    = ucbsp_pkg::IDX_W + ucbsp_pkg::MU_W;
    localparam int Q_W    = 26;
    localparam int W_W    = 24;
    localparam int N_W    = 52;
    localparam int DIVP_W = Q_W + 32;
    localparam int PROD_W = ucbsp_pkg::COORD_W + W_W + 1;
    localparam int ACC_W  = PROD_W + 1;

    localparam logic [ucbsp_pkg::MU_W-1:0]    MU_ONE      = 17'h10000;
    localparam logic [ucbsp_pkg::COUNT_W-1:0] COUNT_RESET = 7'd4;
    localparam logic [31:0]                   RECIP3      = 32'hAAAAAAAB;

    typedef struct packed {
        logic signed [ucbsp_pkg::COORD_W-1:0] x;
        logic signed [ucbsp_pkg::COORD_W-1:0] y;
        logic signed [ucbsp_pkg::COORD_W-1:0] z;
    } knot_t;

    knot_t knot_mem [ucbsp_pkg::MAX_KNOTS];

    logic [ucbsp_pkg::COUNT_W-1:0] knot_count_reg;
    logic [ucbsp_pkg::COUNT_W-1:0] n_eff;
    logic [ucbsp_pkg::IDX_W-1:0]   n_m1;
    logic [ucbsp_pkg::MU_W-1:0]    mu_sat;

    logic [T_W-1:0]   t_reg;
    logic [6:0]       k;
    logic [15:0]      u;
    logic [16:0]      v;
    logic [31:0]      u2_reg;
    logic [32:0]      v2_reg;
    logic [47:0]      u3_reg;
    logic [48:0]      v3_reg;
    logic [N_W-1:0]   num1;
    logic [N_W-1:0]   num2;
    logic [Q_W-1:0]   q_reg [ucbsp_pkg::NUM_TERMS];
    logic [DIVP_W-1:0] div_prod [ucbsp_pkg::NUM_TERMS];
    logic [W_W-1:0]   w_reg [ucbsp_pkg::NUM_TERMS];

    logic [7:0]       term_idx;
    logic [7:0]       term_idx_m1;
    logic             term_ok;
    knot_t            rd_data_reg;
    logic [W_W-1:0]   w_sel_reg;
    logic             term_ok_reg;
    logic signed [ucbsp_pkg::COORD_W-1:0] coord [3];
    logic signed [PROD_W-1:0] prod_reg [3];
    logic             prod_ok_reg;
    logic signed [ACC_W-1:0]  acc_reg [3];

    always_comb
    begin
        if (knot_count_reg == '0)
        begin
            n_eff = 7'd1;
        end
        else if (knot_count_reg > ucbsp_pkg::COUNT_W'(ucbsp_pkg::MAX_KNOTS))
        begin
            n_eff = ucbsp_pkg::COUNT_W'(ucbsp_pkg::MAX_KNOTS);
        end
        else
        begin
            n_eff = knot_count_reg;
        end
    end

    assign n_m1   = ucbsp_pkg::IDX_W'(n_eff - 7'd1);
    assign mu_sat = (req.mu > MU_ONE) ? MU_ONE : req.mu;

    assign k = t_reg[T_W-1:16];
    assign u = t_reg[15:0];
    assign v = MU_ONE - {1'b0, u};

    assign num1 = (N_W'(1) << 50) - (N_W'(u2_reg) << 17) - (N_W'(u2_reg) << 18)
                + (N_W'(u3_reg) << 1) + N_W'(u3_reg);
    assign num2 = (N_W'(1) << 48) + (N_W'(u) * N_W'(3) << 32)
                + (N_W'(u2_reg) * N_W'(3) << 16) - N_W'(u3_reg) * N_W'(3);

    always_comb
    begin
        for (int j = 0; j < ucbsp_pkg::NUM_TERMS; j++)
        begin
            div_prod[j] = DIVP_W'(q_reg[j]) * DIVP_W'(RECIP3);
        end
    end

    assign term_idx    = {1'b0, k} + 8'(cmd.rd_term);
    assign term_idx_m1 = term_idx - 8'd1;
    assign term_ok     = (term_idx != 8'd0) && (term_idx_m1 < {1'b0, n_eff});

    assign coord[0] = rd_data_reg.x;
    assign coord[1] = rd_data_reg.y;
    assign coord[2] = rd_data_reg.z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knot_count_reg <= COUNT_RESET;
            term_ok_reg    <= 1'b0;
            prod_ok_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                knot_count_reg <= cfg_wdata;
            end
            term_ok_reg <= cmd.rd_en && term_ok;
            prod_ok_reg <= term_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            knot_mem[req.knot_index] <= '{x: req.knot_x, y: req.knot_y, z: req.knot_z};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= knot_mem[term_idx_m1[ucbsp_pkg::IDX_W-1:0]];
            w_sel_reg   <= w_reg[cmd.rd_term];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval_start)
        begin
            t_reg <= T_W'(n_m1) * T_W'(mu_sat);
        end
        if (cmd.sq_en)
        begin
            u2_reg <= {16'b0, u} * {16'b0, u};
            v2_reg <= {16'b0, v} * {16'b0, v};
        end
        if (cmd.cube_en)
        begin
            u3_reg <= 48'(u2_reg) * 48'(u);
            v3_reg <= 49'(v2_reg) * 49'(v);
        end
        if (cmd.num_en)
        begin
            q_reg[0] <= Q_W'(v3_reg >> 25);
            q_reg[1] <= num1[50:25];
            q_reg[2] <= num2[50:25];
            q_reg[3] <= Q_W'(u3_reg >> 25);
        end
        if (cmd.div_en)
        begin
            for (int j = 0; j < ucbsp_pkg::NUM_TERMS; j++)
            begin
                w_reg[j] <= div_prod[j][56:33];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 3; d++)
        begin
            prod_reg[d] <= coord[d] * $signed({1'b0, w_sel_reg});
            if (cmd.acc_clr)
            begin
                acc_reg[d] <= '0;
            end
            else if (prod_ok_reg)
            begin
                acc_reg[d] <= acc_reg[d] + ACC_W'(prod_reg[d]);
            end
        end
    end

    assign result.pos_x = acc_reg[0][55:24];
    assign result.pos_y = acc_reg[1][55:24];
    assign result.pos_z = acc_reg[2][55:24];

endmodule

`default_nettype wire

>>> bench/tb_uniform_cubic_bspline_point.sv
// ----------------------------------------------------------------------------
// Testbench for uniform_cubic_bspline_point
// Loads knots and evaluates the curve under several knot counts, including
// the extremes. Each evaluated point is predicted in fixed point by a small
// scoreboard and compared field by field with the result the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uniform_cubic_bspline_point;

    import ucbsp_pkg::*;

    localparam int          RESET_KNOTS   = 4;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          PHASE_ITEMS   = 150;
    localparam longint      RUN_LIMIT_NS  = 2000000;
    localparam longint unsigned ONE_Q16   = 64'd65536;
    localparam longint unsigned WEIGHT_DIV = 64'd100663296;

    class curve_point_board;
        int                 knot_c [MAX_KNOTS][3];
        logic [COUNT_W-1:0] knot_count;
        result_t            expected_points [$];
        int                 failures;

        function new();
            knot_count = COUNT_W'(RESET_KNOTS);
            failures   = 0;
            foreach (knot_c[i, d])
                knot_c[i][d] = 0;
        endfunction

        function longint unsigned knots_in_use();
            if (knot_count < 1)
                return 1;
            if (knot_count > MAX_KNOTS)
                return MAX_KNOTS;
            return knot_count;
        endfunction

        function longint unsigned curve_param(logic [MU_W-1:0] mu);
            longint unsigned m;
            m = mu;
            if (m > ONE_Q16)
                m = ONE_Q16;
            return (knots_in_use() - 1) * m;
        endfunction

        function result_t eval_point(logic [MU_W-1:0] mu);
            longint unsigned n, t, k, u, v, s, i;
            longint unsigned w [4];
            longint          acc [3];
            result_t         p;
            n = knots_in_use();
            t = curve_param(mu);
            k = t >> 16;
            u = t & 64'hFFFF;
            s = ONE_Q16;
            v = s - u;
            w[0] = (v * v * v) / WEIGHT_DIV;
            w[1] = (4 * s * s * s + 3 * u * u * u - 6 * s * u * u) / WEIGHT_DIV;
            w[2] = (s * s * s + 3 * s * s * u + 3 * u * u * v) / WEIGHT_DIV;
            w[3] = (u * u * u) / WEIGHT_DIV;
            for (int d = 0; d < 3; d++)
                acc[d] = 0;
            for (int j = 0; j < 4; j++)
            begin
                if (k + j >= 1)
                begin
                    i = k + j - 1;
                    if (i < n)
                    begin
                        for (int d = 0; d < 3; d++)
                            acc[d] += longint'(knot_c[i][d]) * longint'(w[j]);
                    end
                end
            end
            p.pos_x = 32'(acc[0] >>> 24);
            p.pos_y = 32'(acc[1] >>> 24);
            p.pos_z = 32'(acc[2] >>> 24);
            return p;
        endfunction

        function void note_request(req_t r);
            if (r.req_type == REQ_LOAD)
            begin
                knot_c[r.knot_index][0] = r.knot_x;
                knot_c[r.knot_index][1] = r.knot_y;
                knot_c[r.knot_index][2] = r.knot_z;
            end
            else
                expected_points.push_back(eval_point(r.mu));
        endfunction

        function void report(string field, int want, int got);
            failures++;
            $error("%s expected %0d actual %0d", field, want, got);
        endfunction

        function void check_point(result_t got);
            result_t want;
            if (expected_points.size() == 0)
            begin
                failures++;
                $error("result with no transaction pending: %h", got);
                return;
            end
            want = expected_points.pop_front();
            if (got.pos_x !== want.pos_x)
                report("pos_x", want.pos_x, got.pos_x);
            if (got.pos_y !== want.pos_y)
                report("pos_y", want.pos_y, got.pos_y);
            if (got.pos_z !== want.pos_z)
                report("pos_z", want.pos_z, got.pos_z);
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    req_t                req       = '0;
    logic                done;
    result_t             result;
    logic                cfg_wen   = 1'b0;
    logic [COUNT_W-1:0]  cfg_wdata = '0;

    curve_point_board    board;
    bit                  knot_loaded [MAX_KNOTS];
    int                  max_gap;

    uniform_cubic_bspline_point dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("uniform_cubic_bspline_point: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && board != null)
        begin
            if (start && !busy)
                board.note_request(req);
            if (done === 1'b1)
                board.check_point(result);
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MU_W-1:0] rand_mu();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return MU_W'(ONE_Q16);
            2: return MU_W'($urandom_range(65537, 131071));
            default: return MU_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic send_request(input req_t r);
        int gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic load_knot(input int idx, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z);
        req_t r;
        r.req_type   = REQ_LOAD;
        r.knot_index = IDX_W'(idx);
        r.knot_x     = x;
        r.knot_y     = y;
        r.knot_z     = z;
        r.mu         = MU_W'($urandom);
        knot_loaded[idx] = 1'b1;
        send_request(r);
    endtask

    task automatic evaluate(input logic [MU_W-1:0] mu);
        longint unsigned k, lo, hi;
        req_t            r;
        k  = board.curve_param(mu) >> 16;
        lo = (k == 0) ? 0 : k - 1;
        hi = (k + 2 > MAX_KNOTS - 1) ? MAX_KNOTS - 1 : k + 2;
        for (longint unsigned i = lo; i <= hi; i++)
        begin
            if (!knot_loaded[i])
                load_knot(int'(i), rand_coord(), rand_coord(), rand_coord());
        end
        r.req_type   = REQ_EVAL;
        r.knot_index = IDX_W'($urandom);
        r.knot_x     = $urandom;
        r.knot_y     = $urandom;
        r.knot_z     = $urandom;
        r.mu         = mu;
        send_request(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_knot_count(input int value);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= COUNT_W'(value);
        @(posedge clk);
        cfg_wen   <= 1'b0;
        board.knot_count = COUNT_W'(value);
    endtask

    initial
    begin
        int phase_counts [12] = '{2, 3, 4, 5, 7, 16, 33, 64, 127, 0, 1, 0};
        board   = new();
        max_gap = 5;
        foreach (knot_loaded[i])
            knot_loaded[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_knot(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        load_knot(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        load_knot(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load_knot(3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        load_knot(63, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
        evaluate(17'd0);
        evaluate(17'd65536);
        evaluate(17'd131071);
        evaluate(17'd32768);
        evaluate(17'd1);
        evaluate(17'd65535);
        write_knot_count(0);
        evaluate(17'd0);
        evaluate(17'd65536);
        write_knot_count(1);
        evaluate(17'd40000);
        write_knot_count(127);
        evaluate(17'd65536);
        evaluate(17'd131071);
        write_knot_count(64);
        evaluate(17'd12345);

        foreach (phase_counts[p])
        begin
            write_knot_count((p == 11) ? $urandom_range(0, 127) : phase_counts[p]);
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : 5;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 59) == 0)
                    drain();
                if ($urandom_range(0, 99) < 35)
                    load_knot($urandom_range(0, MAX_KNOTS - 1), rand_coord(),
                              rand_coord(), rand_coord());
                else
                    evaluate(rand_mu());
            end
        end

        start <= 1'b0;
        for (int c = 0; c < 1000 && board.pending() > 0; c++)
            @(posedge clk);
        if (board.pending() > 0)
        begin
            $error("%0d results never arrived", board.pending());
            board.failures += board.pending();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.failures == 0)
            $display("uniform_cubic_bspline_point: match");
        else
            $display("uniform_cubic_bspline_point: mismatch");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ucbsp_pkg.sv
rtl/core/ucbsp_ctrl.sv
rtl/core/ucbsp_datapath.sv
rtl/core/uniform_cubic_bspline_point.sv
bench/tb_uniform_cubic_bspline_point.sv
